>>> sv/order_book_imbalance_features_defines.svh
// assertion macros for the order book imbalance block
`ifndef ORDER_BOOK_IMBALANCE_FEATURES_DEFINES_SVH
`define ORDER_BOOK_IMBALANCE_FEATURES_DEFINES_SVH
`ifndef SYNTHESIS
`define OBIF_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`define OBIF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define OBIF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OBIF_ASSERT_NEVER(name, expr, msg)
`define OBIF_ASSERT_IMPL(name, ante, cons, msg)
`define OBIF_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

>>> sv/obif_pkg.sv
package obif_pkg;

  typedef struct packed {
    logic [31:0] bid_qty;
    logic [31:0] ask_qty;
    logic        bid_present;
    logic        ask_present;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] top_imbalance;
    logic signed [15:0] weighted_imbalance;
    logic [15:0]        bid_rise_ratio;
    logic [15:0]        ask_rise_ratio;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  levels_in_use;
    logic [15:0] decay_factor;
    logic [15:0] pressure_floor;
  } cfg_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_IN_USE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_DECAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_FLOOR = 2'd2;

  localparam logic [4:0]  LEVELS_RESET = 5'd10;
  localparam logic [15:0] DECAY_RESET  = 16'd52429;
  localparam logic [15:0] FLOOR_RESET  = 16'd256;

  // one in q1.16
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

endpackage

>>> sv/obif_fifo.sv
module obif_fifo #(
  parameter int W     = 244,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> sv/obif_front.sv
module obif_front #(
  parameter int MAX_LEVELS = 16,
  parameter int TOP_LEVELS = 3,
  parameter int CNT_W      = 4,
  parameter int TOP_W      = 34,
  parameter int WGT_W      = 52,
  parameter int RISE_W     = 36,
  parameter int REC_W      = 244
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  obif_pkg::in_item_t   in_data,
  output logic                 in_full,
  input  obif_pkg::cfg_t       cfg,
  output logic                 rec_push,
  output logic [REC_W-1:0]     rec_data,
  input  logic                 rec_full
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_WORK = 2'b10
  } fstate_t;

  fstate_t state_r;

  logic [31:0]       bid_r, ask_r;
  logic [31:0]       prev_bid_r, prev_ask_r;
  logic [CNT_W-1:0]  count_r;
  logic [TOP_W-1:0]  top_bid_r, top_ask_r;
  logic [WGT_W-1:0]  wgt_bid_r, wgt_ask_r;
  logic [RISE_W-1:0] rise_bid_r, rise_ask_r;
  logic [16:0]       weight_r;

  // previous snapshot per level, seen_r marks entries written since reset
  logic [31:0]           bid_mem [MAX_LEVELS];
  logic [31:0]           ask_mem [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] seen_r;

  logic [31:0]       prev_b, prev_a, rise_b, rise_a;
  logic [48:0]       wprod_b, wprod_a;
  logic [32:0]       wdec;
  logic [7:0]        lv, n_lv, idx_p1;
  logic              last, commit, accept;
  logic [TOP_W-1:0]  top_bid_nxt, top_ask_nxt;
  logic [WGT_W-1:0]  wgt_bid_nxt, wgt_ask_nxt;
  logic [RISE_W-1:0] rise_bid_nxt, rise_ask_nxt;
  logic [16:0]       weight_nxt;

  assign in_full = (state_r != F_IDLE);
  assign accept  = in_push && (state_r == F_IDLE);

  always_comb begin
    prev_b  = seen_r[count_r] ? prev_bid_r : '0;
    prev_a  = seen_r[count_r] ? prev_ask_r : '0;
    rise_b  = (bid_r > prev_b) ? bid_r - prev_b : '0;
    rise_a  = (ask_r > prev_a) ? ask_r - prev_a : '0;
    wprod_b = 49'(bid_r) * 49'(weight_r);
    wprod_a = 49'(ask_r) * 49'(weight_r);
    wdec    = 33'(weight_r) * 33'(cfg.decay_factor);
    weight_nxt = wdec[32:16];

    // snapshot length clamped to one .. MAX_LEVELS
    lv = 8'(cfg.levels_in_use);
    if (lv == 8'd0) begin
      n_lv = 8'd1;
    end else if (lv > 8'(MAX_LEVELS)) begin
      n_lv = 8'(MAX_LEVELS);
    end else begin
      n_lv = lv;
    end
    idx_p1 = 8'(count_r) + 8'd1;
    last   = (idx_p1 >= n_lv);

    if (32'(count_r) < TOP_LEVELS) begin
      top_bid_nxt = top_bid_r + TOP_W'(bid_r);
      top_ask_nxt = top_ask_r + TOP_W'(ask_r);
    end else begin
      top_bid_nxt = top_bid_r;
      top_ask_nxt = top_ask_r;
    end
    wgt_bid_nxt  = wgt_bid_r + WGT_W'(wprod_b);
    wgt_ask_nxt  = wgt_ask_r + WGT_W'(wprod_a);
    rise_bid_nxt = rise_bid_r + RISE_W'(rise_b);
    rise_ask_nxt = rise_ask_r + RISE_W'(rise_a);

    // the last level waits here while the record queue is full
    commit = (state_r == F_WORK) && (!last || !rec_full);
  end

  assign rec_push = commit && last;
  assign rec_data = {top_bid_nxt, top_ask_nxt, wgt_bid_nxt, wgt_ask_nxt,
                     rise_bid_nxt, rise_ask_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      count_r    <= '0;
      top_bid_r  <= '0;
      top_ask_r  <= '0;
      wgt_bid_r  <= '0;
      wgt_ask_r  <= '0;
      rise_bid_r <= '0;
      rise_ask_r <= '0;
      weight_r   <= obif_pkg::WEIGHT_ONE;
      seen_r     <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_push) begin
            state_r <= F_WORK;
          end
        end
        F_WORK: begin
          if (commit) begin
            state_r         <= F_IDLE;
            seen_r[count_r] <= 1'b1;
            if (last) begin
              count_r    <= '0;
              top_bid_r  <= '0;
              top_ask_r  <= '0;
              wgt_bid_r  <= '0;
              wgt_ask_r  <= '0;
              rise_bid_r <= '0;
              rise_ask_r <= '0;
              weight_r   <= obif_pkg::WEIGHT_ONE;
            end else begin
              count_r    <= CNT_W'(idx_p1);
              top_bid_r  <= top_bid_nxt;
              top_ask_r  <= top_ask_nxt;
              wgt_bid_r  <= wgt_bid_nxt;
              wgt_ask_r  <= wgt_ask_nxt;
              rise_bid_r <= rise_bid_nxt;
              rise_ask_r <= rise_ask_nxt;
              weight_r   <= weight_nxt;
            end
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bid_r      <= in_data.bid_present ? in_data.bid_qty : '0;
      ask_r      <= in_data.ask_present ? in_data.ask_qty : '0;
      prev_bid_r <= bid_mem[count_r];
      prev_ask_r <= ask_mem[count_r];
    end
    if (commit) begin
      bid_mem[count_r] <= bid_r;
      ask_mem[count_r] <= ask_r;
    end
  end

endmodule

>>> sv/obif_back.sv
module obif_back #(
  parameter int TOP_W  = 34,
  parameter int WGT_W  = 52,
  parameter int RISE_W = 36,
  parameter int REC_W  = 244
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [REC_W-1:0]    rec_data,
  input  logic                rec_empty,
  output logic                rec_pop,
  input  obif_pkg::cfg_t      cfg,
  input  logic                out_pop,
  output obif_pkg::out_item_t out_data,
  output logic                out_empty
);

  localparam int SUM_W = (TOP_W > WGT_W) ? ((TOP_W > RISE_W) ? TOP_W : RISE_W)
                                         : ((WGT_W > RISE_W) ? WGT_W : RISE_W);
  localparam int DEN_W = SUM_W + 1;

  localparam int OFS_ARISE = 0;
  localparam int OFS_BRISE = RISE_W;
  localparam int OFS_WASK  = 2 * RISE_W;
  localparam int OFS_WBID  = 2 * RISE_W + WGT_W;
  localparam int OFS_TASK  = 2 * RISE_W + 2 * WGT_W;
  localparam int OFS_TBID  = 2 * RISE_W + 2 * WGT_W + TOP_W;

  localparam logic [4:0] IMB_BITS = 5'd15;
  localparam logic [4:0] PRS_BITS = 5'd16;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_SETUP = 4'b0010,
    B_DIV   = 4'b0100,
    B_DONE  = 4'b1000
  } bstate_t;

  typedef enum logic [3:0] {
    PH_TOP = 4'b0001,
    PH_WGT = 4'b0010,
    PH_BID = 4'b0100,
    PH_ASK = 4'b1000
  } phase_t;

  bstate_t state_r;
  phase_t  phase_r;

  logic [DEN_W-1:0] rem_r, den_r;
  logic [16:0]      quo_r;
  logic [4:0]       step_r, bits_r;
  logic             neg_r, zero_r;
  logic [15:0]      top_res_r, wgt_res_r, bid_res_r, ask_res_r;
  logic             out_valid_r;
  obif_pkg::out_item_t out_data_r;

  logic [DEN_W-1:0] op_b, op_a, imb_tot, imb_diff, rise_tot, flr, norm;
  logic [DEN_W-1:0] num_sel, den_sel;
  logic [DEN_W:0]   cand;
  logic             ge, div_last, load_out;
  logic [DEN_W-1:0] rem_nxt;
  logic [16:0]      quo_nxt;
  logic [14:0]      imb_mag;
  logic [15:0]      imb_res, prs_res;
  logic [15:0]      floor_eff;

  always_comb begin
    case (phase_r)
      PH_TOP: begin
        op_b = DEN_W'(rec_data[OFS_TBID +: TOP_W]);
        op_a = DEN_W'(rec_data[OFS_TASK +: TOP_W]);
      end
      PH_WGT: begin
        op_b = DEN_W'(rec_data[OFS_WBID +: WGT_W]);
        op_a = DEN_W'(rec_data[OFS_WASK +: WGT_W]);
      end
      default: begin
        op_b = DEN_W'(rec_data[OFS_BRISE +: RISE_W]);
        op_a = DEN_W'(rec_data[OFS_ARISE +: RISE_W]);
      end
    endcase

    imb_tot   = op_b + op_a;
    imb_diff  = (op_b >= op_a) ? op_b - op_a : op_a - op_b;
    rise_tot  = imb_tot;
    floor_eff = (cfg.pressure_floor == '0) ? 16'd1 : cfg.pressure_floor;
    flr       = DEN_W'(floor_eff);
    norm      = (rise_tot > flr) ? rise_tot : flr;

    case (phase_r)
      PH_TOP, PH_WGT: begin
        num_sel = imb_diff;
        den_sel = imb_tot;
      end
      PH_BID: begin
        num_sel = op_b;
        den_sel = norm;
      end
      default: begin
        num_sel = op_a;
        den_sel = norm;
      end
    endcase

    // restoring division, the first step compares without a shift
    cand     = (step_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge       = (cand >= {1'b0, den_r});
    rem_nxt  = ge ? DEN_W'(cand - {1'b0, den_r}) : cand[DEN_W-1:0];
    quo_nxt  = {quo_r[15:0], ge};
    div_last = (step_r == bits_r);

    imb_mag = (quo_nxt > 17'd32767) ? 15'h7FFF : quo_nxt[14:0];
    if (zero_r) begin
      imb_res = '0;
    end else if (neg_r) begin
      imb_res = 16'd0 - {1'b0, imb_mag};
    end else begin
      imb_res = {1'b0, imb_mag};
    end
    prs_res = (quo_nxt > 17'd65535) ? 16'hFFFF : quo_nxt[15:0];

    load_out = (state_r == B_DONE) && (!out_valid_r || out_pop);
  end

  assign rec_pop   = load_out;
  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      phase_r     <= PH_TOP;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!rec_empty) begin
            state_r <= B_SETUP;
            phase_r <= PH_TOP;
          end
        end
        B_SETUP: begin
          state_r <= B_DIV;
          step_r  <= '0;
        end
        B_DIV: begin
          step_r <= step_r + 5'd1;
          if (div_last) begin
            case (phase_r)
              PH_TOP: begin
                phase_r <= PH_WGT;
                state_r <= B_SETUP;
              end
              PH_WGT: begin
                phase_r <= PH_BID;
                state_r <= B_SETUP;
              end
              PH_BID: begin
                phase_r <= PH_ASK;
                state_r <= B_SETUP;
              end
              default: begin
                phase_r <= PH_TOP;
                state_r <= B_DONE;
              end
            endcase
          end
        end
        B_DONE: begin
          if (load_out) begin
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_SETUP) begin
      rem_r  <= num_sel;
      den_r  <= den_sel;
      quo_r  <= '0;
      neg_r  <= (op_b < op_a);
      zero_r <= (den_sel == '0);
      bits_r <= ((phase_r == PH_TOP) || (phase_r == PH_WGT)) ? IMB_BITS : PRS_BITS;
    end else if (state_r == B_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      if (div_last) begin
        case (phase_r)
          PH_TOP:  top_res_r <= imb_res;
          PH_WGT:  wgt_res_r <= imb_res;
          PH_BID:  bid_res_r <= prs_res;
          default: ask_res_r <= prs_res;
        endcase
      end
    end
    if (load_out) begin
      out_data_r.top_imbalance      <= top_res_r;
      out_data_r.weighted_imbalance <= wgt_res_r;
      out_data_r.bid_rise_ratio     <= bid_res_r;
      out_data_r.ask_rise_ratio     <= ask_res_r;
    end
  end

endmodule

>>> sv/order_book_imbalance_features.sv
// a level is accepted in the idle state and summed in the work state; the last level of a
// snapshot pushes a record once the queue has room, then four serial divisions give its result
// a new level is taken only after the last one is committed; snapshot rate is set by the
// shared one-bit-per-cycle divider; a 2-deep record queue absorbs short bursts
// reset: synchronous active-low rst_n clears sums, counters, queue and output valid flag, and
// loads the register defaults; the previous-level store reads as zero until written
`include "order_book_imbalance_features_defines.svh"

module order_book_imbalance_features #(
  parameter int MAX_LEVELS = 16,
  parameter int TOP_LEVELS = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  obif_pkg::in_item_t                 in_data,
  output logic                               in_full,
  input  logic                               out_pop,
  output obif_pkg::out_item_t                out_data,
  output logic                               out_empty,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [obif_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [obif_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CNT_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int TOP_W   = 32 + $clog2(TOP_LEVELS + 1);
  localparam int WGT_W   = 48 + $clog2(MAX_LEVELS);
  localparam int RISE_W  = 32 + $clog2(MAX_LEVELS);
  localparam int REC_W   = 2 * TOP_W + 2 * WGT_W + 2 * RISE_W;
  localparam int Q_DEPTH = 2;

  obif_pkg::cfg_t   cfg_r;
  logic             q_push, q_full, q_pop, q_empty;
  logic [REC_W-1:0] q_wr_data, q_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.levels_in_use  <= obif_pkg::LEVELS_RESET;
      cfg_r.decay_factor   <= obif_pkg::DECAY_RESET;
      cfg_r.pressure_floor <= obif_pkg::FLOOR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        obif_pkg::CFG_LEVELS_IN_USE:  cfg_r.levels_in_use  <= cfg_data[4:0];
        obif_pkg::CFG_LEVEL_DECAY:    cfg_r.decay_factor   <= cfg_data;
        obif_pkg::CFG_PRESSURE_FLOOR: cfg_r.pressure_floor <= cfg_data;
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  obif_front #(
    .MAX_LEVELS (MAX_LEVELS),
    .TOP_LEVELS (TOP_LEVELS),
    .CNT_W      (CNT_W),
    .TOP_W      (TOP_W),
    .WGT_W      (WGT_W),
    .RISE_W     (RISE_W),
    .REC_W      (REC_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cfg      (cfg_r),
    .rec_push (q_push),
    .rec_data (q_wr_data),
    .rec_full (q_full)
  );

  obif_fifo #(
    .W     (REC_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  obif_back #(
    .TOP_W  (TOP_W),
    .WGT_W  (WGT_W),
    .RISE_W (RISE_W),
    .REC_W  (REC_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_data  (q_rd_data),
    .rec_empty (q_empty),
    .rec_pop   (q_pop),
    .cfg       (cfg_r),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty)
  );

  `OBIF_ASSERT_NEVER(a_queue_overflow, q_push && q_full, "record pushed into a full queue")
  `OBIF_ASSERT_NEVER(a_queue_underflow, q_pop && q_empty, "record popped from an empty queue")
  `OBIF_ASSERT_NEXT(a_level_busy, in_push && !in_full, in_full, "level work not held off")
  `OBIF_ASSERT_IMPL(a_out_from_queue, $fell(out_empty), $past(q_pop), "result without record")

endmodule
